// File: design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB pixel conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Hue limits and sector geometry
  localparam logic [8:0]  HUE_MAX    = 9'd359;
  localparam logic [5:0]  SECTOR_DEG = 6'd60;
  localparam logic [7:0]  CHAN_MAX   = 8'd255;
  localparam logic [13:0] QT_DEN     = 14'd15300;  // CHAN_MAX * SECTOR_DEG

  // Start angle of each sector
  localparam logic [8:0] SECTOR1_BASE = 9'd60;
  localparam logic [8:0] SECTOR2_BASE = 9'd120;
  localparam logic [8:0] SECTOR3_BASE = 9'd180;
  localparam logic [8:0] SECTOR4_BASE = 9'd240;
  localparam logic [8:0] SECTOR5_BASE = 9'd300;

  // Reciprocal constants: floor(x / d) = (x * M) >> K, exact over the operand range.
  // p: x < 2^16, d = 255, K = 24, M = ceil(2^24 / 255)
  localparam int          RECIP_P_SHIFT = 24;
  localparam logic [16:0] RECIP_P       = 17'd65794;
  // q and t: x < 2^22, d = 15300, K = 36, M = ceil(2^36 / 15300)
  localparam int          RECIP_QT_SHIFT = 36;
  localparam logic [22:0] RECIP_QT       = 23'd4491470;

  typedef enum logic [2:0] {
    SEC_RED_UP     = 3'd0,  // (v, t, p)
    SEC_GREEN_FULL = 3'd1,  // (q, v, p)
    SEC_GREEN_DOWN = 3'd2,  // (p, v, t)
    SEC_BLUE_FULL  = 3'd3,  // (p, q, v)
    SEC_BLUE_DOWN  = 3'd4,  // (t, p, v)
    SEC_RED_FULL   = 3'd5   // (v, p, q)
  } sector_t;

  // Input pixel
  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_pixel_t;

  // Output pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  // Decoded hue with saturation and value
  typedef struct packed {
    sector_t    sector;
    logic [5:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
  } hue_dec_t;

  // Channel candidates ready for sector selection
  typedef struct packed {
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } chan_set_t;

endpackage

// File: design/hsv_to_rgb_converter.sv
// Path: each result passes the decode register, scale stages A, B and C, and
// the output register, from which it transfers out when out_stall is low.
// Throughput: one pixel per cycle; the five register stages advance together
// and hold as a whole while a finished result is stalled at the output.
// Reset: synchronous, active low; clears all stage valid bits, no other state.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined 8-bit HSV to RGB conversion: sector decode, arithmetic, channel
// selection into the output register.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  hsv2rgb_pkg::hsv_pixel_t in_pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output hsv2rgb_pkg::rgb_pixel_t out_pixel
);

  logic                    adv;
  logic                    dec_vld;
  hsv2rgb_pkg::hue_dec_t   dec;
  logic                    chan_vld;
  hsv2rgb_pkg::chan_set_t  chan;
  logic                    out_vld_r;
  hsv2rgb_pkg::rgb_pixel_t out_pix_r, out_pix_nxt;

  // Advance the whole pipe unless the output holds an untaken result
  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  hsv2rgb_sector_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_pix  (in_pixel),
    .dec_vld (dec_vld),
    .dec     (dec)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dec_vld  (dec_vld),
    .dec      (dec),
    .chan_vld (chan_vld),
    .chan     (chan)
  );

  // Route v, p, q, t to red, green, blue by sector
  always_comb begin
    case (chan.sector)
      hsv2rgb_pkg::SEC_RED_UP: begin
        out_pix_nxt = '{red: chan.val, green: chan.t, blue: chan.p};
      end
      hsv2rgb_pkg::SEC_GREEN_FULL: begin
        out_pix_nxt = '{red: chan.q, green: chan.val, blue: chan.p};
      end
      hsv2rgb_pkg::SEC_GREEN_DOWN: begin
        out_pix_nxt = '{red: chan.p, green: chan.val, blue: chan.t};
      end
      hsv2rgb_pkg::SEC_BLUE_FULL: begin
        out_pix_nxt = '{red: chan.p, green: chan.q, blue: chan.val};
      end
      hsv2rgb_pkg::SEC_BLUE_DOWN: begin
        out_pix_nxt = '{red: chan.t, green: chan.p, blue: chan.val};
      end
      default: begin
        out_pix_nxt = '{red: chan.val, green: chan.p, blue: chan.q};
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= chan_vld;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pixel = out_pix_r;

endmodule

// File: design/hsv2rgb_sector_decode.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector_decode
// Clamps the hue, splits it into a 60-degree sector and an offset within it.
// ----------------------------------------------------------------------------
module hsv2rgb_sector_decode (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  hsv2rgb_pkg::hsv_pixel_t in_pix,
  output logic                    dec_vld,
  output hsv2rgb_pkg::hue_dec_t   dec
);

  logic [8:0]           hue_clamp;
  hsv2rgb_pkg::sector_t sector;
  logic [8:0]           base;
  logic [8:0]           offset;
  logic                 vld_r;
  hsv2rgb_pkg::hue_dec_t dec_r, dec_nxt;

  // Saturate hue and find its sector
  always_comb begin
    hue_clamp = (in_pix.hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : in_pix.hue;
    if (hue_clamp >= hsv2rgb_pkg::SECTOR5_BASE) begin
      sector = hsv2rgb_pkg::SEC_RED_FULL;
      base   = hsv2rgb_pkg::SECTOR5_BASE;
    end else if (hue_clamp >= hsv2rgb_pkg::SECTOR4_BASE) begin
      sector = hsv2rgb_pkg::SEC_BLUE_DOWN;
      base   = hsv2rgb_pkg::SECTOR4_BASE;
    end else if (hue_clamp >= hsv2rgb_pkg::SECTOR3_BASE) begin
      sector = hsv2rgb_pkg::SEC_BLUE_FULL;
      base   = hsv2rgb_pkg::SECTOR3_BASE;
    end else if (hue_clamp >= hsv2rgb_pkg::SECTOR2_BASE) begin
      sector = hsv2rgb_pkg::SEC_GREEN_DOWN;
      base   = hsv2rgb_pkg::SECTOR2_BASE;
    end else if (hue_clamp >= hsv2rgb_pkg::SECTOR1_BASE) begin
      sector = hsv2rgb_pkg::SEC_GREEN_FULL;
      base   = hsv2rgb_pkg::SECTOR1_BASE;
    end else begin
      sector = hsv2rgb_pkg::SEC_RED_UP;
      base   = 9'd0;
    end
    offset = hue_clamp - base;

    dec_nxt.sector = sector;
    dec_nxt.frac   = offset[5:0];
    dec_nxt.sat    = in_pix.saturation;
    dec_nxt.val    = in_pix.brightness;
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_vld = vld_r;
  assign dec     = dec_r;

endmodule

// File: design/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Three-stage arithmetic: numerators, products with value, exact floor
// division by 255 and 15300 through reciprocal multiplication.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   dec_vld,
  input  hsv2rgb_pkg::hue_dec_t  dec,
  output logic                   chan_vld,
  output hsv2rgb_pkg::chan_set_t chan
);

  // Stage A: numerators
  logic                 a_vld_r;
  hsv2rgb_pkg::sector_t a_sector_r;
  logic [7:0]           a_val_r;
  logic [7:0]           a_np_r, a_np_nxt;
  logic [13:0]          a_nq_r, a_nq_nxt;
  logic [13:0]          a_nt_r, a_nt_nxt;
  logic [5:0]           rest_deg;

  // Stage B: products with value
  logic                 b_vld_r;
  hsv2rgb_pkg::sector_t b_sector_r;
  logic [7:0]           b_val_r;
  logic [15:0]          b_pp_r, b_pp_nxt;
  logic [21:0]          b_pq_r, b_pq_nxt;
  logic [21:0]          b_pt_r, b_pt_nxt;

  // Stage C: quotients
  logic                   c_vld_r;
  hsv2rgb_pkg::chan_set_t c_r, c_nxt;
  logic [32:0]            mul_p;
  logic [44:0]            mul_q;
  logic [44:0]            mul_t;

  // Build numerators 255-s, 15300-s*f, 15300-s*(60-f)
  always_comb begin
    rest_deg = hsv2rgb_pkg::SECTOR_DEG - dec.frac;
    a_np_nxt = hsv2rgb_pkg::CHAN_MAX - dec.sat;
    a_nq_nxt = hsv2rgb_pkg::QT_DEN - (14'(dec.sat) * 14'(dec.frac));
    a_nt_nxt = hsv2rgb_pkg::QT_DEN - (14'(dec.sat) * 14'(rest_deg));
  end

  // Multiply by value
  always_comb begin
    b_pp_nxt = 16'(a_val_r) * 16'(a_np_r);
    b_pq_nxt = 22'(a_val_r) * 22'(a_nq_r);
    b_pt_nxt = 22'(a_val_r) * 22'(a_nt_r);
  end

  // Divide by constants through reciprocals
  always_comb begin
    mul_p = 33'(b_pp_r) * 33'(hsv2rgb_pkg::RECIP_P);
    mul_q = 45'(b_pq_r) * 45'(hsv2rgb_pkg::RECIP_QT);
    mul_t = 45'(b_pt_r) * 45'(hsv2rgb_pkg::RECIP_QT);
    c_nxt.sector = b_sector_r;
    c_nxt.val    = b_val_r;
    c_nxt.p      = mul_p[hsv2rgb_pkg::RECIP_P_SHIFT +: 8];
    c_nxt.q      = mul_q[hsv2rgb_pkg::RECIP_QT_SHIFT +: 8];
    c_nxt.t      = mul_t[hsv2rgb_pkg::RECIP_QT_SHIFT +: 8];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= dec_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      a_sector_r <= dec.sector;
      a_val_r    <= dec.val;
      a_np_r     <= a_np_nxt;
      a_nq_r     <= a_nq_nxt;
      a_nt_r     <= a_nt_nxt;
      b_sector_r <= a_sector_r;
      b_val_r    <= a_val_r;
      b_pp_r     <= b_pp_nxt;
      b_pq_r     <= b_pq_nxt;
      b_pt_r     <= b_pt_nxt;
      c_r        <= c_nxt;
    end
  end

  assign chan_vld = c_vld_r;
  assign chan     = c_r;

endmodule

// File: verif/hsv_to_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both pixel channels of the HSV to RGB converter. It predicts each
// RGB result from the accepted HSV pixel and compares it with the output in
// order. It reports the failure count and the number of results still due.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  hsv_pixel_t in_pixel,
  input  logic       out_valid,
  input  logic       out_stall,
  input  rgb_pixel_t out_pixel,
  output int         error_count,
  output int         pending_count
);

  rgb_pixel_t expected_rgb[$];

  // Exact integer HSV to RGB conversion of one pixel
  function automatic rgb_pixel_t convert_hsv(hsv_pixel_t px);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned f;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t     sec;
    rgb_pixel_t  rgb;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    // Clamp hue beyond the last degree
    if (h > HUE_MAX) h = HUE_MAX;
    if (s == 0) begin
      rgb.red   = 8'(v);
      rgb.green = 8'(v);
      rgb.blue  = 8'(v);
      return rgb;
    end
    sec = sector_t'(h / SECTOR_DEG);
    f   = h % SECTOR_DEG;
    p   = (v * (CHAN_MAX - s)) / CHAN_MAX;
    q   = (v * (QT_DEN - s * f)) / QT_DEN;
    t   = (v * (QT_DEN - s * (SECTOR_DEG - f))) / QT_DEN;
    case (sec)
      SEC_RED_UP: begin
        rgb = {8'(v), 8'(t), 8'(p)};
      end
      SEC_GREEN_FULL: begin
        rgb = {8'(q), 8'(v), 8'(p)};
      end
      SEC_GREEN_DOWN: begin
        rgb = {8'(p), 8'(v), 8'(t)};
      end
      SEC_BLUE_FULL: begin
        rgb = {8'(p), 8'(q), 8'(v)};
      end
      SEC_BLUE_DOWN: begin
        rgb = {8'(t), 8'(p), 8'(v)};
      end
      default: begin
        rgb = {8'(v), 8'(p), 8'(q)};
      end
    endcase
    return rgb;
  endfunction

  initial error_count = 0;

  assign pending_count = expected_rgb.size();

  // Record predictions on input transfers, compare on output transfers
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (!rst_n) begin
      expected_rgb.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_rgb = {expected_rgb, convert_hsv(in_pixel)};
      end
      if (out_valid && !out_stall) begin
        if (expected_rgb.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                     out_pixel.red, out_pixel.green, out_pixel.blue);
          end
          error_count++;
        end else begin
          want = expected_rgb.pop_front();
          if (out_pixel.red !== want.red || out_pixel.green !== want.green ||
              out_pixel.blue !== want.blue) begin
            if (error_count < 10) begin
              $display("%0t: mismatch expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       out_pixel.red, out_pixel.green, out_pixel.blue);
            end
            error_count++;
          end
        end
      end
    end
  end

endmodule

// File: verif/hsv_to_rgb_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Drives HSV pixels into the converter through directed corner cases and
// random phases with varying sender gaps and receiver stalls, including a
// long output hold-off. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 340;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  hsv_pixel_t in_pixel;
  logic       out_valid;
  logic       out_stall;
  rgb_pixel_t out_pixel;
  int         error_count;
  int         pending_count;

  int gap_pct;
  int stall_pct;
  int hold_trigger;

  hsv_to_rgb_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel(out_pixel)
  );

  hsv_to_rgb_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after a generous bound
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one pixel after random gaps and wait for its transfer
  task automatic send_pixel(input hsv_pixel_t px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_hsv(input int h, input int s, input int v);
    hsv_pixel_t px;
    px.hue        = 9'(h);
    px.saturation = 8'(s);
    px.brightness = 8'(v);
    send_pixel(px);
  endtask

  // Random pixel, weighted toward legal hues and saturation corners
  function automatic hsv_pixel_t random_pixel();
    hsv_pixel_t px;
    int         pick;
    pick = $urandom_range(99);
    px.hue = (pick < 85) ? 9'($urandom_range(359)) : 9'($urandom_range(511, 360));
    pick = $urandom_range(99);
    if (pick < 10) px.saturation = 8'd0;
    else if (pick < 15) px.saturation = 8'd255;
    else px.saturation = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 5) px.brightness = 8'd0;
    else if (pick < 10) px.brightness = 8'd255;
    else px.brightness = 8'($urandom_range(255));
    return px;
  endfunction

  // Drain: stop offering until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (PHASE_ITEMS) send_pixel(random_pixel());
    drain();
  endtask

  // Stimulus and verdict
  initial begin
    gap_pct      = 0;
    stall_pct    = 0;
    hold_trigger = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pixel     = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Sector boundaries at full saturation and value
    send_hsv(0, 255, 255);
    send_hsv(59, 255, 255);
    send_hsv(60, 255, 255);
    send_hsv(119, 255, 255);
    send_hsv(120, 255, 255);
    send_hsv(179, 255, 255);
    send_hsv(180, 255, 255);
    send_hsv(239, 255, 255);
    send_hsv(240, 255, 255);
    send_hsv(299, 255, 255);
    send_hsv(300, 255, 255);
    send_hsv(359, 255, 255);
    // Hue past the last degree clamps
    send_hsv(360, 200, 180);
    send_hsv(400, 255, 255);
    send_hsv(511, 1, 255);
    // Grey pixels at zero saturation
    send_hsv(0, 0, 0);
    send_hsv(200, 0, 255);
    send_hsv(511, 0, 77);
    // Value and saturation extremes
    send_hsv(30, 255, 0);
    send_hsv(90, 1, 255);
    send_hsv(210, 1, 1);
    send_hsv(330, 128, 1);
    send_hsv(150, 254, 254);
    drain();

    // Fill the pipeline against a long output hold-off
    hold_trigger++;
    repeat (20) send_pixel(random_pixel());
    drain();

    run_phase(0, 0);
    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(23, 23);

    // Let the pipeline settle before the verdict
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
